// ===== hw/rtl/isadma_pkg.sv =====
// Package for the ISA DMA channel controller core.
// Holds channel count, widths, port decode constants and the request kind enum.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isadma_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int COUNT_W      = 17;
    localparam int BASE_W       = 16;
    localparam int PAGE_W       = 8;
    localparam int MADDR_W      = 24;

    localparam logic [CH_W-1:0]    PROG_CH     = CH_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_65536 = 17'h10000;

    localparam logic [7:0] PORT_ADDR1  = 8'h02;
    localparam logic [7:0] PORT_COUNT1 = 8'h03;
    localparam logic [7:0] PORT_MASK   = 8'h0A;
    localparam logic [7:0] PORT_MODE   = 8'h0B;
    localparam logic [7:0] PORT_CLR_FF = 8'h0C;
    localparam logic [7:0] PORT_PAGE1  = 8'h83;

    typedef enum logic [1:0] {
        KIND_PORT_WR = 2'd0,
        KIND_PORT_RD = 2'd1,
        KIND_DMA_REQ = 2'd2
    } t_kind;

endpackage

`default_nettype wire

// ===== hw/rtl/isadma_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module isadma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                 i_wdata,
    input  wire                             i_re,
    input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/isa_dma_channel_controller_core.sv =====
// Top level of the ISA DMA channel controller: port decode, channel state, DMA address.
// Depends on isadma_pkg and isadma_ram (transfer count store).
//
// channel   dir  tdata (low bit up)                                   tuser
// s         in   port_addr[7:0] write_data[15:8] channel_sel[17:16]    mode[1:0]
// m         out  port_read_data[7:0] mem_request[8] mem_address[32:9]
//                transfer_idle[33]                                    -
//
// One transfer per cycle sustained unless the output stalls; a transfer is registered
// in stage 1, then the output register. Transfer counts sit in a RAM read on accept,
// written when stage 1 fires, forwarding the last write. Reset (synchronous, active
// low) clears registers, and counts via per-channel valid bits; no clearing pass. A
// stalled output holds stage 1 and blocks input only when both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module isa_dma_channel_controller_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // port_addr, write_data, channel_sel, zero pad
    input  wire  [1:0]  i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata    // port_read_data, mem_request, mem_address,
                                     // transfer_idle, zero pad
);

    localparam int N  = isadma_pkg::NUM_CHANNELS;
    localparam int CW = isadma_pkg::CH_W;
    localparam int KW = isadma_pkg::COUNT_W;
    localparam int AW = isadma_pkg::MADDR_W;

    // stage 1
    logic        r_s1_valid;
    logic [1:0]  r_s1_mode;
    logic [7:0]  r_s1_port;
    logic [7:0]  r_s1_data;
    logic [1:0]  r_s1_ch;

    // channel state
    logic [isadma_pkg::BASE_W-1:0] r_base1, n_base1;
    logic [KW-1:0]                 r_reload1, n_reload1;
    logic [isadma_pkg::PAGE_W-1:0] r_page1, n_page1;
    logic                          r_ff, n_ff;
    logic [N-1:0]                  r_masked, n_masked;
    logic [N-1:0]                  r_dec, n_dec;
    logic [N-1:0]                  r_auto, n_auto;
    logic [N-1:0]                  r_tc_vld;

    // forwarding of last count write
    logic          r_fwd_valid;
    logic [CW-1:0] r_fwd_ch;
    logic [KW-1:0] r_fwd_cnt;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_rd, n_out_rd;
    logic        r_out_req, n_out_req;
    logic [AW-1:0] r_out_addr, n_out_addr;
    logic        r_out_idle, n_out_idle;

    logic          s_fire, s1_fire;
    logic          ram_we, ram_wen;
    logic [CW-1:0] ram_waddr;
    logic [KW-1:0] ram_wdata, ram_rdata;

    logic [CW-1:0] ch_idx, wch_idx;
    logic          ch_ok, wch_ok;
    logic [KW-1:0] tc_cur, tc_eff, reload_c;
    logic [isadma_pkg::BASE_W-1:0] base_c;
    logic [isadma_pkg::PAGE_W-1:0] page_c;
    logic [AW-1:0] addr_pb;
    logic [15:0]   cnt_lo16;

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_fire;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign ram_wen    = ram_we && s1_fire;

    isadma_ram #(
        .WIDTH (KW),
        .DEPTH (N)
    ) u_tc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wen),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (s_fire),
        .i_raddr (i_s_tdata[16 +: CW]),
        .o_rdata (ram_rdata)
    );

    assign ch_idx  = r_s1_ch[CW-1:0];
    assign ch_ok   = 32'(r_s1_ch) < N;
    assign wch_idx = r_s1_data[CW-1:0];
    assign wch_ok  = 32'(r_s1_data[1:0]) < N;

    always_comb begin
        if (r_fwd_valid && (r_fwd_ch == ch_idx)) begin
            tc_cur = r_fwd_cnt;
        end else if (r_tc_vld[ch_idx]) begin
            tc_cur = ram_rdata;
        end else begin
            tc_cur = '0;
        end
    end

    assign reload_c = (ch_idx == isadma_pkg::PROG_CH) ? r_reload1 : '0;
    assign base_c   = (ch_idx == isadma_pkg::PROG_CH) ? r_base1   : '0;
    assign page_c   = (ch_idx == isadma_pkg::PROG_CH) ? r_page1   : '0;
    assign tc_eff   = (r_auto[ch_idx] && (tc_cur > reload_c)) ? '0 : tc_cur;
    assign addr_pb  = {page_c, 16'h0000} + {8'h00, base_c};

    always_comb begin
        n_base1    = r_base1;
        n_reload1  = r_reload1;
        n_page1    = r_page1;
        n_ff       = r_ff;
        n_masked   = r_masked;
        n_dec      = r_dec;
        n_auto     = r_auto;
        ram_we     = 1'b0;
        ram_waddr  = ch_idx;
        ram_wdata  = '0;
        n_out_rd   = '0;
        n_out_req  = 1'b0;
        n_out_addr = '0;
        n_out_idle = 1'b0;
        cnt_lo16   = {r_s1_data, r_reload1[7:0]};

        unique case (isadma_pkg::t_kind'(r_s1_mode))
            isadma_pkg::KIND_PORT_WR: begin
                unique case (r_s1_port)
                    isadma_pkg::PORT_ADDR1: begin
                        if (r_ff) begin
                            n_base1 = {r_s1_data, r_base1[7:0]};
                        end else begin
                            n_base1 = {r_base1[15:8], r_s1_data};
                        end
                        n_ff = !r_ff;
                    end
                    isadma_pkg::PORT_COUNT1: begin
                        if (r_ff) begin
                            n_reload1 = (cnt_lo16 == 16'h0000) ? isadma_pkg::COUNT_65536
                                                              : {1'b0, cnt_lo16};
                            ram_we    = 1'b1;
                            ram_waddr = isadma_pkg::PROG_CH;
                            ram_wdata = '0;
                        end else begin
                            n_reload1 = {1'b0, r_reload1[15:8], r_s1_data};
                        end
                        n_ff = !r_ff;
                    end
                    isadma_pkg::PORT_MASK: begin
                        if (wch_ok) begin
                            n_masked[wch_idx] = r_s1_data[2];
                        end
                    end
                    isadma_pkg::PORT_MODE: begin
                        if (wch_ok) begin
                            n_dec[wch_idx]  = r_s1_data[5];
                            n_auto[wch_idx] = r_s1_data[4];
                        end
                    end
                    isadma_pkg::PORT_CLR_FF: begin
                        n_ff = 1'b0;
                    end
                    isadma_pkg::PORT_PAGE1: begin
                        n_page1 = r_s1_data;
                    end
                    default: begin
                    end
                endcase
            end
            isadma_pkg::KIND_PORT_RD: begin
                if (!r_s1_port[7] && (r_s1_port == isadma_pkg::PORT_COUNT1)) begin
                    n_out_rd = r_ff ? r_reload1[15:8] : r_reload1[7:0];
                end
            end
            isadma_pkg::KIND_DMA_REQ: begin
                if (!ch_ok || r_masked[ch_idx] || (tc_eff > reload_c)) begin
                    n_out_idle = 1'b1;
                end else begin
                    n_out_req  = 1'b1;
                    n_out_addr = r_dec[ch_idx] ? addr_pb - {7'h00, tc_eff}
                                               : addr_pb + {7'h00, tc_eff};
                    ram_we     = 1'b1;
                    ram_waddr  = ch_idx;
                    ram_wdata  = tc_eff + KW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_base1     <= '0;
            r_reload1   <= '0;
            r_page1     <= '0;
            r_ff        <= 1'b0;
            r_masked    <= '0;
            r_dec       <= '0;
            r_auto      <= '0;
            r_tc_vld    <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_base1   <= n_base1;
                r_reload1 <= n_reload1;
                r_page1   <= n_page1;
                r_ff      <= n_ff;
                r_masked  <= n_masked;
                r_dec     <= n_dec;
                r_auto    <= n_auto;
                if (ram_we) begin
                    r_tc_vld[ram_waddr] <= 1'b1;
                    r_fwd_valid         <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_mode <= i_s_tuser;
            r_s1_port <= i_s_tdata[7:0];
            r_s1_data <= i_s_tdata[15:8];
            r_s1_ch   <= i_s_tdata[17:16];
        end
        if (s1_fire) begin
            r_out_rd   <= n_out_rd;
            r_out_req  <= n_out_req;
            r_out_addr <= n_out_addr;
            r_out_idle <= n_out_idle;
            if (ram_we) begin
                r_fwd_ch  <= ram_waddr;
                r_fwd_cnt <= ram_wdata;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_idle, r_out_addr, r_out_req, r_out_rd};

    a_req_idle_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_req && r_out_idle))
        else $error("mem_request and transfer_idle both set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid && $stable(o_m_tdata))
        else $error("stalled output transfer changed");

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid)
        else $error("stage fire did not load output register");

    a_read_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_rd != 8'h00) |-> !r_out_req && !r_out_idle)
        else $error("port read data with dma flags");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted with both stages full");

endmodule

`default_nettype wire

// ===== tb/sv/isadma_result_checker.sv =====
// Result checker for the ISA DMA channel controller core: watches both stream channels,
// predicts each result from its own copy of the channel state and compares field by field.
// Depends on isadma_pkg.
`timescale 1ns / 1ps

module isadma_result_checker
    import isadma_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [23:0] i_s_tdata,   // port_addr, write_data, channel_sel, zero pad
    input  wire  [1:0]  i_s_tuser,   // mode
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [39:0] i_m_tdata,   // port_read_data, mem_request, mem_address,
                                     // transfer_idle, zero pad
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic               idle;
        logic [MADDR_W-1:0] addr;
        logic               mem_req;
        logic [7:0]         rd_data;
    } dma_result_t;

    logic [BASE_W-1:0]  chan_base     [NUM_CHANNELS];
    logic [COUNT_W-1:0] chan_reload   [NUM_CHANNELS];
    logic [COUNT_W-1:0] chan_count    [NUM_CHANNELS];
    logic [PAGE_W-1:0]  chan_page     [NUM_CHANNELS];
    logic               chan_mask     [NUM_CHANNELS];
    logic               chan_down     [NUM_CHANNELS];
    logic               chan_autoinit [NUM_CHANNELS];
    logic               addr_ff;

    dma_result_t expected_results [$];
    dma_result_t exp_res;
    dma_result_t got_res;
    dma_result_t new_res;

    task automatic clear_channel_state();
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_base[i]     = '0;
            chan_reload[i]   = '0;
            chan_count[i]    = '0;
            chan_page[i]     = '0;
            chan_mask[i]     = 1'b0;
            chan_down[i]     = 1'b0;
            chan_autoinit[i] = 1'b0;
        end
        addr_ff = 1'b0;
    endtask

    task automatic predict_bus_event(input logic [1:0] mode, input logic [7:0] port,
                                     input logic [7:0] data, input logic [1:0] ch,
                                     output dma_result_t res);
        logic [1:0]         wr_ch;
        logic [MADDR_W-1:0] sum;
        res   = '0;
        wr_ch = data[1:0];
        case (mode)
            KIND_PORT_WR: begin
                case (port)
                    PORT_ADDR1: begin
                        if (addr_ff) chan_base[PROG_CH][15:8] = data;
                        else         chan_base[PROG_CH][7:0]  = data;
                        addr_ff = ~addr_ff;
                    end
                    PORT_COUNT1: begin
                        if (addr_ff) begin
                            chan_reload[PROG_CH] = {1'b0, data, chan_reload[PROG_CH][7:0]};
                            if (chan_reload[PROG_CH] == '0) chan_reload[PROG_CH] = COUNT_65536;
                            chan_count[PROG_CH] = '0;
                        end else begin
                            chan_reload[PROG_CH] = {1'b0, chan_reload[PROG_CH][15:8], data};
                        end
                        addr_ff = ~addr_ff;
                    end
                    PORT_MASK: begin
                        if (int'(wr_ch) < NUM_CHANNELS) chan_mask[wr_ch] = data[2];
                    end
                    PORT_MODE: begin
                        if (int'(wr_ch) < NUM_CHANNELS) begin
                            chan_down[wr_ch]     = data[5];
                            chan_autoinit[wr_ch] = data[4];
                        end
                    end
                    PORT_CLR_FF: addr_ff = 1'b0;
                    PORT_PAGE1:  chan_page[PROG_CH] = data;
                    default: ;
                endcase
            end
            KIND_PORT_RD: begin
                if (!port[7] && port == PORT_COUNT1)
                    res.rd_data = addr_ff ? chan_reload[PROG_CH][15:8]
                                          : chan_reload[PROG_CH][7:0];
            end
            KIND_DMA_REQ: begin
                if (int'(ch) >= NUM_CHANNELS || chan_mask[ch]) begin
                    res.idle = 1'b1;
                end else begin
                    if (chan_autoinit[ch] && chan_count[ch] > chan_reload[ch])
                        chan_count[ch] = '0;
                    if (chan_count[ch] > chan_reload[ch]) begin
                        res.idle = 1'b1;
                    end else begin
                        sum = {chan_page[ch], 16'h0000} + MADDR_W'(chan_base[ch]);
                        if (chan_down[ch]) sum = sum - MADDR_W'(chan_count[ch]);
                        else               sum = sum + MADDR_W'(chan_count[ch]);
                        chan_count[ch] = chan_count[ch] + 1'b1;
                        res.mem_req    = 1'b1;
                        res.addr       = sum;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_channel_state();
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_res = i_m_tdata[33:0];
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result: tdata %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got_res.rd_data !== exp_res.rd_data) begin
                        $error("port_read_data: expected %h, got %h",
                               exp_res.rd_data, got_res.rd_data);
                        o_fail_count++;
                    end
                    if (got_res.mem_req !== exp_res.mem_req) begin
                        $error("mem_request: expected %b, got %b",
                               exp_res.mem_req, got_res.mem_req);
                        o_fail_count++;
                    end
                    if (got_res.addr !== exp_res.addr) begin
                        $error("mem_address: expected %h, got %h",
                               exp_res.addr, got_res.addr);
                        o_fail_count++;
                    end
                    if (got_res.idle !== exp_res.idle) begin
                        $error("transfer_idle: expected %b, got %b",
                               exp_res.idle, got_res.idle);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_bus_event(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8],
                                  i_s_tdata[17:16], new_res);
                expected_results.push_back(new_res);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_isa_dma_channel_controller_core.sv =====
// Testbench top for the ISA DMA channel controller core: clock, reset, bus event
// stimulus, result-side back-pressure and the verdict.
// Depends on isadma_pkg, isa_dma_channel_controller_core and isadma_result_checker.
`timescale 1ns / 1ps

module tb_isa_dma_channel_controller_core;
    import isadma_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;

    int fail_count;
    int pending;
    int sent_count;
    bit steady;
    bit stim_done;

    isa_dma_channel_controller_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    isadma_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2400000;
        $display("== FAIL ==");
        $finish;
    end

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_item(input logic [1:0] mode, input logic [7:0] port,
                             input logic [7:0] data, input logic [1:0] ch);
        while (!steady && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, ch, data, port};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic port_wr(input logic [7:0] port, input logic [7:0] data);
        send_item(KIND_PORT_WR, port, data, 2'($urandom_range(3)));
    endtask

    task automatic port_rd(input logic [7:0] port);
        send_item(KIND_PORT_RD, port, 8'($urandom_range(255)), 2'($urandom_range(3)));
    endtask

    task automatic dma_req(input logic [1:0] ch);
        send_item(KIND_DMA_REQ, 8'($urandom_range(255)), 8'($urandom_range(255)), ch);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic program_and_burst();
        logic [7:0] lo;
        logic [7:0] hi;
        int         n;
        if ($urandom_range(9) < 8) port_wr(PORT_CLR_FF, 8'($urandom_range(255)));
        if ($urandom_range(1) == 1) begin
            port_wr(PORT_ADDR1, 8'($urandom_range(255)));
            port_wr(PORT_ADDR1, 8'($urandom_range(255)));
        end
        if ($urandom_range(3) != 0) begin
            lo = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
            hi = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h00;
            port_wr(PORT_COUNT1, lo);
            port_wr(PORT_COUNT1, hi);
        end
        if ($urandom_range(2) == 0) port_wr(PORT_PAGE1, 8'($urandom_range(255)));
        if ($urandom_range(1) == 1) port_wr(PORT_MODE, 8'($urandom_range(255)));
        if ($urandom_range(2) == 0)
            port_wr(PORT_MASK, 8'($urandom_range(255)) & (($urandom_range(3) == 0) ?
                    8'hFF : 8'hFB));
        if ($urandom_range(3) == 0) port_rd(PORT_COUNT1);
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(15) == 0) port_rd(PORT_COUNT1);
            else if ($urandom_range(3) != 0) dma_req(PROG_CH);
            else dma_req(2'($urandom_range(3)));
        end
    endtask

    task automatic noise_item();
        logic [1:0] mode;
        logic [7:0] port;
        mode = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        case ($urandom_range(7))
            0: port = PORT_ADDR1;
            1: port = PORT_COUNT1;
            2: port = PORT_MASK;
            3: port = PORT_MODE;
            4: port = PORT_CLR_FF;
            5: port = PORT_PAGE1;
            default: port = 8'($urandom_range(255));
        endcase
        send_item(mode, port, 8'($urandom_range(255)), 2'($urandom_range(3)));
    endtask

    // Result side: random back-pressure plus one long hold-off while input keeps coming.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && sent_count >= 600) begin
                hold_done = 1'b1;
                hold_left = 300;
                m_tready <= 1'b0;
            end else if (steady || stim_done) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 31);
            end
        end
    end

    initial begin
        bit drained_mid;
        drained_mid = 1'b0;
        sent_count  = 0;
        steady      = 1'b0;
        stim_done   = 1'b0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_PORT_WR;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, full-range programming, wrap, direction, mask,
        // auto-init restart, dropped bit 16 on low count write, ignored ports, mode 3
        port_rd(PORT_COUNT1);
        dma_req(PROG_CH);
        dma_req(PROG_CH);
        port_wr(PORT_CLR_FF, 8'h00);
        port_wr(PORT_ADDR1, 8'hFF);
        port_wr(PORT_ADDR1, 8'hFF);
        port_wr(PORT_PAGE1, 8'hFF);
        port_wr(PORT_COUNT1, 8'h00);
        port_wr(PORT_COUNT1, 8'h00);
        port_rd(PORT_COUNT1);
        port_wr(PORT_MODE, 8'h21);
        dma_req(PROG_CH);
        dma_req(PROG_CH);
        port_wr(PORT_MODE, 8'h11);
        dma_req(PROG_CH);
        port_wr(PORT_MASK, 8'h05);
        dma_req(PROG_CH);
        port_wr(PORT_MASK, 8'h01);
        port_wr(PORT_COUNT1, 8'h02);
        port_rd(PORT_COUNT1);
        dma_req(PROG_CH);
        port_rd(PORT_PAGE1);
        port_wr(PORT_MODE, 8'hFF);
        dma_req(2'd3);
        send_item(2'd3, 8'hFF, 8'hFF, 2'd3);
        port_wr(8'hFF, 8'hFF);
        wait_results_drained();

        while (sent_count < 2025) begin
            if ($urandom_range(99) < 70) program_and_burst();
            else noise_item();
            if (!drained_mid && sent_count >= 1000) begin
                drained_mid = 1'b1;
                wait_results_drained();
            end
            steady = (sent_count >= 1300 && sent_count < 1600);
        end

        stim_done = 1'b1;
        steady    = 1'b0;
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
